// ===== hw/rtl/mwif_pkg.sv =====
// ----------------------------------------------------------------------------
// mwif_pkg: shared types and constants of the multi-writer mailbox FIFO
// Holds the bus function codes, the item structs and the FIFO sizing.
// ----------------------------------------------------------------------------
package mwif_pkg;

  // FIFO sizing
  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Word layout
  localparam int DATA_W     = 32;
  localparam int ID_W       = 6;
  localparam int ENTRY_W    = DATA_W - ID_W;
  localparam int FILL_W     = 7;
  localparam int FLAG_CNT   = 63;
  localparam int FLAG_HI_W  = FLAG_CNT - DATA_W;

  localparam logic [ID_W-1:0]   NO_FLAG_ID = 6'h3f;
  localparam logic [DATA_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

  // Bus function codes
  typedef enum logic [2:0] {
    FN_PUSH      = 3'd0,
    FN_POP       = 3'd1,
    FN_RD_FLAGS0 = 3'd2,
    FN_RD_FLAGS1 = 3'd3,
    FN_CLR_FLAGS0 = 3'd4,
    FN_CLR_FLAGS1 = 3'd5
  } func_t;

  // Input item
  typedef struct packed {
    logic [2:0]        func;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  // Control from the decoder to the entry store
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] entry;
  } store_ctrl_t;

  // Status from the entry store
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [ENTRY_W-1:0] head;
    logic [CNT_W-1:0]   cnt_nxt;
  } store_stat_t;

  // Control from the decoder to the overflow flags
  typedef struct packed {
    logic              set_en;
    logic [ID_W-1:0]   set_id;
    logic              clr0;
    logic              clr1;
    logic [DATA_W-1:0] clr_mask;
  } flag_ctrl_t;

endpackage

// ===== hw/rtl/mwif_store.sv =====
// ----------------------------------------------------------------------------
// mwif_store: entry memory, pointers and fill count of the mailbox FIFO
// Keeps the oldest entry prefetched in a head register so a pop needs no
// memory access of its own.
// ----------------------------------------------------------------------------
module mwif_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mwif_pkg::store_ctrl_t ctrl,
  output mwif_pkg::store_stat_t stat
);
  import mwif_pkg::*;

  logic [ENTRY_W-1:0] mem [FIFO_DEPTH];
  logic [ENTRY_W-1:0] head_r;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               full, empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);

  // Advance pointers and count
  always_comb begin
    rd_ptr_nxt = ctrl.pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    wr_ptr_nxt = ctrl.push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (ctrl.push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctrl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write the memory; prefetch the next head, forwarding a write to it
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr_r] <= ctrl.entry;
    end
    if (ctrl.push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= ctrl.entry;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign stat.full    = full;
  assign stat.empty   = empty;
  assign stat.head    = head_r;
  assign stat.cnt_nxt = cnt_nxt;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("fill count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !ctrl.push)
    else $error("push into full FIFO");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !ctrl.pop)
    else $error("pop from empty FIFO");

  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (rd_ptr_r == wr_ptr_r))
    else $error("pointers disagree with fill count");
`endif

endmodule

// ===== hw/rtl/mwif_flags.sv =====
// ----------------------------------------------------------------------------
// mwif_flags: per-writer overflow flags of the mailbox FIFO
// Sets a writer's flag on a dropped push; clears flags by write-one.
// ----------------------------------------------------------------------------
module mwif_flags (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mwif_pkg::flag_ctrl_t        ctrl,
  output logic [mwif_pkg::DATA_W-1:0] flags0,
  output logic [mwif_pkg::DATA_W-1:0] flags1
);
  import mwif_pkg::*;

  logic [FLAG_CNT-1:0] flags_r, flags_nxt;
  logic [FLAG_CNT-1:0] set_vec;

  // Decode the writer id into a flag bit; id 63 maps to nothing
  always_comb begin
    set_vec = '0;
    if (ctrl.set_en && (ctrl.set_id != NO_FLAG_ID)) begin
      set_vec[ctrl.set_id] = 1'b1;
    end
  end

  // Set on overflow, clear by write-one
  always_comb begin
    flags_nxt = flags_r | set_vec;
    if (ctrl.clr0) begin
      flags_nxt[DATA_W-1:0] = flags_r[DATA_W-1:0] & ~ctrl.clr_mask;
    end
    if (ctrl.clr1) begin
      flags_nxt[FLAG_CNT-1:DATA_W] = flags_r[FLAG_CNT-1:DATA_W]
                                     & ~ctrl.clr_mask[FLAG_HI_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  assign flags0 = flags_r[DATA_W-1:0];
  assign flags1 = {1'b0, flags_r[FLAG_CNT-1:DATA_W]};

endmodule

// ===== hw/rtl/multi_writer_ipc_fifo.sv =====
// ----------------------------------------------------------------------------
// multi_writer_ipc_fifo: shared inter-processor mailbox FIFO
// Decodes bus accesses, drives the entry store and overflow flags, and
// returns one result item per access through an output register.
// ----------------------------------------------------------------------------
// Every accepted bus access yields exactly one result item in the next cycle,
// and a new access can be accepted every cycle unless in_stall is high; the
// whole access is resolved combinationally because the oldest entry is held
// prefetched in a head register next to the 64-entry memory. in_stall rises
// only while a result sits in the output register and out_stall holds it. A
// push into a full FIFO is dropped and flags its writer (bits 5:0, ids 0-62);
// a pop of an empty FIFO returns all ones. There is no clearing pass after reset.
module multi_writer_ipc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mwif_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mwif_pkg::out_item_t  out_item
);
  import mwif_pkg::*;

  store_ctrl_t       st_ctrl;
  store_stat_t       st_stat;
  flag_ctrl_t        fl_ctrl;
  logic [DATA_W-1:0] flags0, flags1;
  logic              accept;
  logic [DATA_W-1:0] result;
  logic              out_valid_r;
  out_item_t         out_item_r;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Decode the access
  always_comb begin
    st_ctrl          = '0;
    st_ctrl.entry    = in_item.write_data[DATA_W-1:ID_W];
    fl_ctrl          = '0;
    fl_ctrl.set_id   = in_item.write_data[ID_W-1:0];
    fl_ctrl.clr_mask = in_item.write_data;
    result           = '0;
    unique case (in_item.func)
      FN_PUSH: begin
        st_ctrl.push   = accept & ~st_stat.full;
        fl_ctrl.set_en = accept & st_stat.full;
      end
      FN_POP: begin
        st_ctrl.pop = accept & ~st_stat.empty;
        result      = st_stat.empty ? EMPTY_WORD : {st_stat.head, {ID_W{1'b0}}};
      end
      FN_RD_FLAGS0: result = flags0;
      FN_RD_FLAGS1: result = flags1;
      FN_CLR_FLAGS0: fl_ctrl.clr0 = accept;
      FN_CLR_FLAGS1: fl_ctrl.clr1 = accept;
      default: result = '0;
    endcase
  end

  mwif_store u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (st_ctrl),
    .stat (st_stat)
  );

  mwif_flags u_flags (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fl_ctrl),
    .flags0(flags0),
    .flags1(flags1)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r.read_data  <= result;
      out_item_r.fill_level <= FILL_W'(st_stat.cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !accept)
    else $error("item accepted over a held result");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_item_r)))
    else $error("held result changed");
`endif

endmodule
